// ----- src/stbs_pkg.sv -----
// Shared types and constants for the size tier bucket selector.
`default_nettype none
package stbs_pkg;
  localparam int unsigned IdBits    = 16;
  localparam int unsigned RatioFrac = 16;
  localparam int unsigned OutCap    = 32;
  localparam int unsigned PairMin   = 2;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MIN_SIZE    = 3'd0,
    CFG_RATIO_LOW   = 3'd1,
    CFG_RATIO_HIGH  = 3'd2,
    CFG_MIN_GROUP   = 3'd3,
    CFG_MAX_GROUP   = 3'd4,
    CFG_ENFORCE_MIN = 3'd5
  } cfg_idx_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic ins_start;    // latch a new item, begin insertion scan
    logic ins_step;     // one shift step of the insertion
    logic tier_start;   // clear tier walk
    logic tier_eval;    // evaluate join tests for entry
    logic div_step;     // one division step
    logic tier_commit;  // commit join or new tier
    logic pick_start;   // clear tier pick
    logic pick_step;    // examine one tier
    logic pick_retry;   // retry with threshold two
    logic emit_load;    // load output register from current member
    logic emit_next;    // advance to next member
    logic clear_set;    // item count back to zero
  } stbs_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic ins_done;
    logic ins_keep;     // item still to be placed (room left)
    logic walk_done;    // all entries walked
    logic need_div;     // join candidate needs a division
    logic div_done;
    logic pick_done;
    logic found;
    logic emit_last;
  } stbs_sts_t;
endpackage
`default_nettype wire

// ----- src/stbs_ctrl.sv -----
// Controller state machine of the size tier bucket selector.
`default_nettype none
module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid,
  input  wire logic      in_last_i,
  output logic           in_stall,
  input  wire logic      out_stall,
  output logic           out_valid,
  input  wire logic      enforce_i,
  input  wire stbs_sts_t sts_i,
  output stbs_cmd_t      cmd_o
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_INS   = 10'b0000000010,
    S_TSTRT = 10'b0000000100,
    S_TEVAL = 10'b0000001000,
    S_TDIV  = 10'b0000010000,
    S_TCOM  = 10'b0000100000,
    S_PICK  = 10'b0001000000,
    S_PICK2 = 10'b0010000000,
    S_LOAD  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   retried_q, retried_d;

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    retried_d = retried_q;
    cmd_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.ins_start = 1'b1;
          last_d  = in_last_i;
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (sts_i.ins_done || !sts_i.ins_keep) begin
          state_d = last_q ? S_TSTRT : S_IDLE;
        end else begin
          cmd_o.ins_step = 1'b1;
        end
      end
      S_TSTRT: begin
        cmd_o.tier_start = 1'b1;
        state_d = S_TEVAL;
      end
      S_TEVAL: begin
        if (sts_i.walk_done) begin
          cmd_o.pick_start = 1'b1;
          retried_d = 1'b0;
          state_d = S_PICK;
        end else begin
          cmd_o.tier_eval = 1'b1;
          state_d = S_TDIV;
        end
      end
      S_TDIV: begin
        if (!sts_i.need_div) begin
          state_d = S_TCOM;
        end else if (sts_i.div_done) begin
          state_d = S_TCOM;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_TCOM: begin
        cmd_o.tier_commit = 1'b1;
        state_d = S_TEVAL;
      end
      S_PICK: begin
        if (sts_i.pick_done) begin
          if (!sts_i.found && !enforce_i && !retried_q) begin
            cmd_o.pick_retry = 1'b1;
            retried_d = 1'b1;
          end else begin
            state_d = S_PICK2;
          end
        end else begin
          cmd_o.pick_step = 1'b1;
        end
      end
      S_PICK2: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.emit_load = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts_i.emit_last) begin
            cmd_o.clear_set = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d = S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      last_q    <= 1'b0;
      retried_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      retried_q <= retried_d;
    end
  end
endmodule
`default_nettype wire

// ----- src/stbs_dp.sv -----
// Datapath of the size tier bucket selector: stores, tier walk, divider, pick.
`default_nettype none
module stbs_dp
  import stbs_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32,
  parameter int unsigned SIZE_BITS = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire stbs_cmd_t            cmd_i,
  output stbs_sts_t                 sts_o,
  input  wire logic [IdBits-1:0]    in_id_i,
  input  wire logic [47:0]          in_size_i,
  input  wire logic [47:0]          min_size_i,
  input  wire logic [15:0]          ratio_low_i,
  input  wire logic [19:0]          ratio_high_i,
  input  wire logic [5:0]           min_group_i,
  input  wire logic [5:0]           max_group_i,
  output logic [IdBits-1:0]         member_id_o,
  output logic                      found_o,
  output logic                      last_result_o
);
  localparam int unsigned IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AvgW = SIZE_BITS + FRAC_BITS;
  localparam int unsigned TotW = AvgW + CntW;
  localparam int unsigned PrdW = AvgW + 20;
  localparam int unsigned CmpW = SIZE_BITS + FRAC_BITS + RatioFrac;
  localparam int unsigned DivSteps = TotW;
  localparam int unsigned DsW = $clog2(DivSteps + 1);

  // Item stores (registers read at chosen addresses via small muxes).
  logic [SIZE_BITS-1:0] size_mem [MAX_ITEMS];
  logic [IdBits-1:0]    id_mem   [MAX_ITEMS];
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      pos_q;
  logic [SIZE_BITS-1:0] new_size_q;
  logic [IdBits-1:0]    new_id_q;
  logic                 keep_q;

  logic [IdxW-1:0] pos_m1;
  logic [IdxW-1:0] pos_ix;
  assign pos_m1 = IdxW'(pos_q - CntW'(1));
  assign pos_ix = pos_q[IdxW-1:0];
  logic shift_here;
  assign shift_here = (pos_q != '0) && (size_mem[pos_m1] > new_size_q);

  // Insertion: shift larger entries up one per cycle, then place item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pos_q  <= '0;
      keep_q <= 1'b0;
    end else begin
      if (cmd_i.ins_start) begin
        keep_q <= (cnt_q < CntW'(MAX_ITEMS));
        pos_q  <= cnt_q;
      end else if (cmd_i.ins_step) begin
        if (shift_here) begin
          pos_q <= pos_q - CntW'(1);
        end else begin
          cnt_q <= cnt_q + CntW'(1);
          keep_q <= 1'b0;
        end
      end else if (cmd_i.clear_set) begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_start) begin
      new_size_q <= in_size_i[SIZE_BITS-1:0];
      new_id_q   <= in_id_i;
    end
    if (cmd_i.ins_step) begin
      if (shift_here) begin
        size_mem[pos_ix] <= size_mem[pos_m1];
        id_mem[pos_ix]   <= id_mem[pos_m1];
      end else begin
        size_mem[pos_ix] <= new_size_q;
        id_mem[pos_ix]   <= new_id_q;
      end
    end
  end
  // Insertion finishes when the item has been placed (keep_q drops).
  assign sts_o.ins_keep = keep_q;
  assign sts_o.ins_done = 1'b0;

  // Tier walk state.
  logic [CntW-1:0]      wi_q;
  logic [AvgW-1:0]      avg_q;
  logic [CntW-1:0]      mem_q;
  logic                 have_q;
  logic [CntW-1:0]      tstart_q;
  logic [CntW-1:0]      tlen_q;
  logic [SIZE_BITS-1:0] cur_s_q;
  logic                 cand_q;
  logic                 small_q;
  logic [TotW-1:0]      rem_q, quo_q, tot_q;
  logic [DsW-1:0]       dcnt_q;
  logic                 divrun_q;

  logic [SIZE_BITS-1:0] s_w;
  assign s_w = size_mem[wi_q[IdxW-1:0]];
  logic [PrdW-1:0] p_lo, p_hi;
  assign p_lo = PrdW'(avg_q) * PrdW'(ratio_low_i);
  assign p_hi = PrdW'(avg_q) * PrdW'(ratio_high_i);
  logic [PrdW-1:0] lhs;
  assign lhs = PrdW'(s_w) << (FRAC_BITS + RatioFrac);
  logic [AvgW:0] min_sh;
  assign min_sh = (AvgW+1)'(min_size_i) << FRAC_BITS;
  logic s_small;
  assign s_small = (48'(s_w) < min_size_i);
  logic ca, cb;
  assign ca = (lhs > p_lo) && (lhs < p_hi);
  assign cb = s_small && ((AvgW+1)'(avg_q) < min_sh);

  // Second join test on divided average (product of the registered quotient).
  logic [AvgW-1:0] navg;
  assign navg = quo_q[AvgW-1:0];
  logic [SIZE_BITS-1:0] smallest;
  assign smallest = size_mem[tstart_q[IdxW-1:0]];
  logic [PrdW-1:0] sm_sh, p_n;
  assign sm_sh = PrdW'(smallest) << (FRAC_BITS + RatioFrac);
  assign p_n   = PrdW'(navg) * PrdW'(ratio_low_i);
  logic join_w;
  assign join_w = cand_q && (small_q || (sm_sh > p_n));

  // Restoring divider, one bit per cycle; divisor is members+1.
  logic [CntW:0]   dvs;
  assign dvs = (CntW+1)'(mem_q) + (CntW+1)'(1);
  logic [TotW:0] trial;
  assign trial = (TotW+1)'({rem_q[TotW-2:0], tot_q[TotW-1]}) - (TotW+1)'(dvs);

  // Pick state.
  logic [CntW-1:0] tier_start_a [MAX_ITEMS];
  logic [CntW-1:0] tier_len_a   [MAX_ITEMS];
  logic [CntW-1:0] ntiers_q, pk_q, best_start_q, best_len_q;
  logic [5:0]      thr_q;
  logic            bfound_q;
  logic [CntW-1:0] emit_k_q;
  logic [CntW-1:0] cut_w;
  logic [CntW-1:0] pl;
  assign pl = tier_len_a[pk_q[IdxW-1:0]];
  logic [CntW-1:0] tl;
  assign tl = ({2'b0, pl} < 8'(max_group_i)) ? pl : CntW'(max_group_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q     <= '0;
      avg_q    <= '0;
      mem_q    <= '0;
      have_q   <= 1'b0;
      divrun_q <= 1'b0;
      dcnt_q   <= '0;
      ntiers_q <= '0;
      pk_q     <= '0;
      bfound_q <= 1'b0;
      emit_k_q <= '0;
      cand_q   <= 1'b0;
    end else begin
      if (cmd_i.tier_start) begin
        wi_q     <= '0;
        have_q   <= 1'b0;
        ntiers_q <= '0;
      end
      if (cmd_i.tier_eval) begin
        cur_s_q  <= s_w;
        small_q  <= s_small;
        cand_q   <= have_q && (ca || cb);
        tot_q    <= TotW'(mem_q) * TotW'(avg_q) + (TotW'(s_w) << FRAC_BITS);
        rem_q    <= '0;
        quo_q    <= '0;
        dcnt_q   <= '0;
        divrun_q <= have_q && (ca || cb);
      end
      if (cmd_i.div_step) begin
        if (!trial[TotW]) begin
          rem_q <= trial[TotW-1:0];
          quo_q <= {quo_q[TotW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[TotW-2:0], tot_q[TotW-1]};
          quo_q <= {quo_q[TotW-2:0], 1'b0};
        end
        tot_q  <= tot_q << 1;
        dcnt_q <= dcnt_q + DsW'(1);
      end
      if (cmd_i.tier_commit) begin
        wi_q <= wi_q + CntW'(1);
        if (join_w) begin
          mem_q <= mem_q + CntW'(1);
          avg_q <= navg;
          tier_len_a[IdxW'(ntiers_q - CntW'(1))] <=
            tier_len_a[IdxW'(ntiers_q - CntW'(1))] + CntW'(1);
        end else begin
          tier_start_a[ntiers_q[IdxW-1:0]] <= wi_q;
          tier_len_a[ntiers_q[IdxW-1:0]]   <= CntW'(1);
          tstart_q <= wi_q;
          ntiers_q <= ntiers_q + CntW'(1);
          avg_q    <= AvgW'(cur_s_q) << FRAC_BITS;
          mem_q    <= CntW'(1);
          have_q   <= 1'b1;
        end
      end
      if (cmd_i.pick_start || cmd_i.pick_retry) begin
        pk_q     <= '0;
        bfound_q <= 1'b0;
        best_len_q <= '0;
        thr_q    <= cmd_i.pick_retry ? 6'(PairMin) : min_group_i;
      end
      if (cmd_i.pick_step) begin
        pk_q <= pk_q + CntW'(1);
        if ((8'(pl) >= 8'(thr_q)) && (!bfound_q || tl > best_len_q)) begin
          bfound_q     <= 1'b1;
          best_len_q   <= tl;
          best_start_q <= tier_start_a[pk_q[IdxW-1:0]];
        end
      end
      if (cmd_i.pick_start) emit_k_q <= '0;
      if (cmd_i.emit_next) emit_k_q <= emit_k_q + CntW'(1);
      if (cmd_i.clear_set) emit_k_q <= '0;
    end
  end

  assign cut_w = (8'(best_len_q) > 8'(OutCap)) ? CntW'(OutCap) : best_len_q;

  // Output register loaded per member.
  logic ok_w;
  assign ok_w = bfound_q && (cut_w != '0);
  logic [CntW-1:0] ea;
  assign ea = best_start_q + emit_k_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      member_id_o   <= ok_w ? id_mem[ea[IdxW-1:0]] : '0;
      found_o       <= ok_w;
      last_result_o <= !ok_w || (emit_k_q + CntW'(1) == cut_w);
    end
  end

  assign sts_o.walk_done = (wi_q == cnt_q);
  assign sts_o.need_div  = divrun_q;
  assign sts_o.div_done  = (dcnt_q == DsW'(DivSteps));
  assign sts_o.pick_done = (pk_q == ntiers_q);
  assign sts_o.found     = bfound_q;
  assign sts_o.emit_last = last_result_o;
endmodule
`default_nettype wire

// ----- src/size_tier_bucket_select_core.sv -----
// Top level of the size tier bucket selector; one item is worked on at a time.
// An item that does not close the set stalls the input while each larger entry is shifted up
// and the item is placed; when the set is full the item is dropped. A closing item then takes
// each stored entry through evaluate, divide and commit, the divider running SIZE_BITS+FRAC_BITS+
// clog2(MAX_ITEMS+1) steps per join candidate, then examines each tier (twice on retry).
// A result is held while stalled. Reset clears counters and control, not stores.
`default_nettype none
module size_tier_bucket_select_core
  import stbs_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32,
  parameter int unsigned SIZE_BITS = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [IdBits-1:0]     item_id_i,
  input  wire logic [47:0]           item_size_i,
  input  wire logic                  last_item_i,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [IdBits-1:0]          member_id_o,
  output logic                       found_o,
  output logic                       last_result_o,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [47:0]           cfg_data_i
);
  logic [47:0] min_size_q;
  logic [15:0] ratio_low_q;
  logic [19:0] ratio_high_q;
  logic [5:0]  min_group_q, max_group_q;
  logic        enforce_q;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q   <= 48'd52428800;
      ratio_low_q  <= 16'd32768;
      ratio_high_q <= 20'd98304;
      min_group_q  <= 6'd4;
      max_group_q  <= 6'd32;
      enforce_q    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        CFG_MIN_SIZE:    min_size_q   <= cfg_data_i;
        CFG_RATIO_LOW:   ratio_low_q  <= cfg_data_i[15:0];
        CFG_RATIO_HIGH:  ratio_high_q <= cfg_data_i[19:0];
        CFG_MIN_GROUP:   min_group_q  <= cfg_data_i[5:0];
        CFG_MAX_GROUP:   max_group_q  <= cfg_data_i[5:0];
        CFG_ENFORCE_MIN: enforce_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  stbs_cmd_t cmd;
  stbs_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_last_i(last_item_i), .in_stall,
    .out_stall, .out_valid, .enforce_i(enforce_q), .sts_i(sts), .cmd_o(cmd)
  );

  stbs_dp #(.MAX_ITEMS(MAX_ITEMS), .SIZE_BITS(SIZE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_id_i(item_id_i), .in_size_i(item_size_i),
    .min_size_i(min_size_q), .ratio_low_i(ratio_low_q), .ratio_high_i(ratio_high_q),
    .min_group_i(min_group_q), .max_group_i(max_group_q),
    .member_id_o, .found_o, .last_result_o
  );
endmodule
`default_nettype wire

// ----- src/stbs_checker.sv -----
// Port-level checker for the size tier bucket selector, with its bind.
`default_nettype none
module stbs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic found_o,
  input wire logic last_result_o
);
  // Input is never taken while a result is offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |-> !out_valid) else $error("input accepted during answer");
  // A not-found result is always the final one.
  a_nf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !found_o) |-> last_result_o) else $error("not-found not last");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(found_o)))
    else $error("result dropped");
endmodule
bind size_tier_bucket_select_core stbs_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .found_o, .last_result_o
);
`default_nettype wire

// ----- sim/tb_size_tier_bucket_select_core.sv -----
// Self-checking testbench for the size tier bucket selector core.
module tb_size_tier_bucket_select_core;
  timeunit 1ns;
  timeprecision 1ps;
  import stbs_pkg::*;

  localparam int MaxItems = 32;
  localparam int FracBits = 16;
  localparam int StallLimit = 20000;
  localparam int HoldCycles = 600;

  typedef struct packed {
    logic [15:0] id;
    logic        found;
    logic        last;
  } member_t;

  typedef struct {
    logic [15:0] id;
    logic [47:0] size;
    logic        last;
    logic        typed;
    logic [15:0] exp_id;
    logic        exp_found;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] item_id_i = '0;
  logic [47:0] item_size_i = '0;
  logic last_item_i = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] member_id_o;
  logic found_o;
  logic last_result_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  size_tier_bucket_select_core i_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .item_id_i, .item_size_i, .last_item_i,
    .out_valid, .out_stall, .member_id_o, .found_o, .last_result_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the configuration.
  logic [47:0] c_min = 48'd52428800;
  logic [15:0] c_rlo = 16'd32768;
  logic [19:0] c_rhi = 20'd98304;
  logic [5:0]  c_ming = 6'd4;
  logic [5:0]  c_maxg = 6'd32;
  logic        c_enf = 1'b0;

  // Predictor copy of the sorted set and the tier walk.
  logic [47:0] srt_size [MaxItems];
  logic [15:0] srt_id [MaxItems];
  int          held = 0;
  logic [63:0] avg_fx = '0;
  int          tier_mem = 0;
  int          t_first [MaxItems];
  int          t_size [MaxItems];

  member_t member_q [$];
  int errors = 0;
  int s_idle = 0;
  int r_idle = 0;
  int hold_left = 0;

  // Pick the first largest tier reaching the threshold, cut to max_group.
  function automatic int pick_tier(int nt, int thr, output int cut);
    int best, tl;
    best = -1;
    cut = 0;
    for (int i = 0; i < nt; i++) begin
      if (t_size[i] < thr) continue;
      tl = (t_size[i] < int'(c_maxg)) ? t_size[i] : int'(c_maxg);
      if (best < 0 || tl > cut) begin
        best = i;
        cut = tl;
      end
    end
    return best;
  endfunction

  // Sorted insertion of one item and, on the closing item, the tier answer.
  task automatic plan_bucket(logic [15:0] id, logic [47:0] sz, logic lst);
    int p, nt, best, cut;
    logic [47:0] s;
    logic [127:0] a, lhs, tot, sm;
    logic [63:0] navg;
    logic ca, cb, join_ok;
    member_t r;
    if (held < MaxItems) begin
      p = held;
      while (p > 0 && srt_size[p-1] > sz) begin
        srt_size[p] = srt_size[p-1];
        srt_id[p] = srt_id[p-1];
        p--;
      end
      srt_size[p] = sz;
      srt_id[p] = id;
      held++;
    end
    if (!lst) return;
    nt = 0;
    for (int i = 0; i < held; i++) begin
      s = srt_size[i];
      join_ok = 1'b0;
      navg = '0;
      if (nt > 0) begin
        a = 128'(avg_fx);
        lhs = 128'(s) << (FracBits + RatioFrac);
        ca = (lhs > a * 128'(c_rlo)) && (lhs < a * 128'(c_rhi));
        cb = (s < c_min) && (avg_fx < (64'(c_min) << FracBits));
        if (ca || cb) begin
          tot = 128'(tier_mem) * a + (128'(s) << FracBits);
          navg = 64'(tot / 128'(tier_mem + 1));
          sm = 128'(srt_size[t_first[nt-1]]) << (FracBits + RatioFrac);
          if (s < c_min || sm > 128'(navg) * 128'(c_rlo)) join_ok = 1'b1;
        end
      end
      if (join_ok) begin
        tier_mem++;
        avg_fx = navg;
        t_size[nt-1]++;
      end else begin
        t_first[nt] = i;
        t_size[nt] = 1;
        nt++;
        avg_fx = 64'(s) << FracBits;
        tier_mem = 1;
      end
    end
    best = pick_tier(nt, int'(c_ming), cut);
    if (best < 0 && !c_enf) best = pick_tier(nt, PairMin, cut);
    held = 0;
    if (best < 0 || cut == 0) begin
      r.id = 16'd0;
      r.found = 1'b0;
      r.last = 1'b1;
      member_q = {member_q, r};
    end else begin
      if (cut > OutCap) cut = OutCap;
      for (int k = 0; k < cut; k++) begin
        r.id = srt_id[t_first[best] + k];
        r.found = 1'b1;
        r.last = (k + 1 == cut);
        member_q = {member_q, r};
      end
    end
  endtask

  // Offer one item, wait for it to be taken, then predict.
  task automatic send_item(logic [15:0] id, logic [47:0] sz, logic lst,
                           logic typed = 1'b0, logic [15:0] eid = '0, logic efound = 1'b0);
    int n_prior;
    member_t t;
    while ($urandom_range(99) < s_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    item_id_i <= id;
    item_size_i <= sz;
    last_item_i <= lst;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_prior = member_q.size();
    plan_bucket(id, sz, lst);
    // Typed answers replace the predicted one for the obvious rows.
    if (typed) begin
      while (member_q.size() > n_prior) void'(member_q.pop_back());
      t.id = eid;
      t.found = efound;
      t.last = 1'b1;
      member_q = {member_q, t};
    end
  endtask

  // One register write; the caller lowers valid after the last one.
  task automatic cfg_write(cfg_idx_e idx, logic [47:0] v);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_MIN_SIZE:    c_min = v;
      CFG_RATIO_LOW:   c_rlo = v[15:0];
      CFG_RATIO_HIGH:  c_rhi = v[19:0];
      CFG_MIN_GROUP:   c_ming = v[5:0];
      CFG_MAX_GROUP:   c_maxg = v[5:0];
      CFG_ENFORCE_MIN: c_enf = v[0];
      default: ;
    endcase
  endtask

  // Wait until every answer is out and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (member_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rnd48();
    return {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
  endfunction

  // Sizes cluster around a per-set base so that tiers actually form.
  function automatic logic [47:0] rnd_size(logic [47:0] base);
    logic [63:0] v;
    case ($urandom_range(9))
      0: return rnd48();
      1: return 48'($urandom_range(0, 1000));
      default: begin
        v = 64'(base) * 64'($urandom_range(100, 160)) / 64'd100;
        return v[47:0];
      end
    endcase
  endfunction

  // Register settings per phase; the first two are the extremes.
  task automatic set_phase(int ph);
    logic [47:0] mn;
    logic [15:0] rl;
    logic [19:0] rh;
    logic [5:0] mg, xg;
    logic en;
    case (ph)
      1: begin mn = '0; rl = 16'd1; rh = 20'hFFFFF; mg = 6'd2; xg = 6'd32; en = 1'b0; end
      2: begin
        mn = 48'hFFFF_FFFF_FFFF; rl = 16'hFFFF; rh = 20'd65537; mg = 6'd32; xg = 6'd2;
        en = 1'b1;
      end
      3: begin mn = 48'd52428800; rl = 16'd32768; rh = 20'd98304; mg = 6'd0; xg = 6'd0;
        en = 1'b0; end
      default: begin
        mn = rnd48() >> $urandom_range(0, 40);
        rl = 16'($urandom_range(1, 65535));
        rh = 20'($urandom_range(65537, 1048575));
        mg = 6'($urandom_range(0, 32));
        xg = 6'($urandom_range(1, 32));
        en = 1'($urandom_range(1));
      end
    endcase
    cfg_write(CFG_MIN_SIZE, mn);
    cfg_write(CFG_RATIO_LOW, 48'(rl));
    cfg_write(CFG_RATIO_HIGH, 48'(rh));
    cfg_write(CFG_MIN_GROUP, 48'(mg));
    cfg_write(CFG_MAX_GROUP, 48'(xg));
    cfg_write(CFG_ENFORCE_MIN, 48'(en));
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checking and receiver stalls.
  initial begin
    member_t e;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        if (member_q.size() == 0) begin
          $display("%0t: unexpected result id %h found %b last %b", $time, member_id_o,
                   found_o, last_result_o);
          errors++;
        end else begin
          e = member_q.pop_front();
          if (member_id_o !== e.id) begin
            $display("%0t: member_id expected %h actual %h", $time, e.id, member_id_o);
            errors++;
          end
          if (found_o !== e.found) begin
            $display("%0t: found expected %b actual %b", $time, e.found, found_o);
            errors++;
          end
          if (last_result_o !== e.last) begin
            $display("%0t: last_result expected %b actual %b", $time, e.last, last_result_o);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < r_idle);
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_size_tier_bucket_select_core: errors");
    $finish;
  end

  // Stimulus: directed table, then random sets over several phases.
  initial begin
    dir_row_t rows [$];
    logic [47:0] base;
    int n, len;
    rows = '{
      '{16'd1, 48'd1, 1'b1, 1'b1, 16'd0, 1'b0},
      '{16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 16'd0, 1'b0},
      '{16'd10, 48'd100, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd11, 48'd100, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd12, 48'd100, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd13, 48'd100, 1'b1, 1'b0, 16'd0, 1'b0},
      '{16'd0, 48'd0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd20, 48'd0, 1'b1, 1'b0, 16'd0, 1'b0},
      '{16'd30, 48'd100000000, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd31, 48'd110000000, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd32, 48'd90000000, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd33, 48'd1, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd34, 48'h100_0000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd35, 48'h100_0000_0005, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd36, 48'd95000000, 1'b1, 1'b0, 16'd0, 1'b0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin s_idle = 19; r_idle = 74; end
        1: begin s_idle = 74; r_idle = 19; end
        default: begin s_idle = 0; r_idle = 0; end
      endcase
      if (ph > 0) set_phase(ph);
      if (ph == 0) begin
        foreach (rows[i])
          send_item(rows[i].id, rows[i].size, rows[i].last, rows[i].typed, rows[i].exp_id,
                    rows[i].exp_found);
      end else begin
        // The receiver holds off while items keep coming in.
        if (ph == 4) hold_left = HoldCycles;
        n = 0;
        while (n < 40) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(28, 35) : $urandom_range(1, 8);
          base = rnd48() >> $urandom_range(0, 40);
          for (int k = 0; k < len; k++)
            send_item(16'($urandom()), rnd_size(base), k == len - 1);
          n += len;
          if (ph == 6) drain();
        end
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && member_q.size() == 0) begin
      $display("tb_size_tier_bucket_select_core: clean");
    end else begin
      $display("tb_size_tier_bucket_select_core: errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/stbs_pkg.sv
src/stbs_ctrl.sv
src/stbs_dp.sv
src/size_tier_bucket_select_core.sv
src/stbs_checker.sv
sim/tb_size_tier_bucket_select_core.sv
